// ===== rtl/core/one_shot_timer_bank_core_assert.svh =====
// Assertion macros for the one-shot timer bank core.
`ifndef ONE_SHOT_TIMER_BANK_CORE_ASSERT_SVH
`define ONE_SHOT_TIMER_BANK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define OSTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ostb: implication check failed");
// Next-cycle implication, checked out of reset.
`define OSTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ostb: next-cycle check failed");
`else
`define OSTB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OSTB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ostb_pkg.sv =====
// Shared types and constants of the one-shot timer bank.
package ostb_pkg;

  // Operation codes on the input word
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // Result kinds
  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [15:0] STEP_RESET = 16'd1000;
  localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  timer_id;
    logic [31:0] interval_ms;
  } ostb_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] which_timer;
    logic       armed;
    logic       last;
  } ostb_out_t;

  // One timer entry in the store
  typedef struct packed {
    logic [31:0] interval;
    logic [31:0] elapsed;
  } ostb_entry_t;

  // Update unit result
  typedef struct packed {
    logic        expired;
    logic [31:0] elapsed;
  } ostb_upd_t;

endpackage

// ===== rtl/core/one_shot_timer_bank_core.sv =====
// Top level of the one-shot timer bank: sequencer, armed flags and output register.
//
// Input channel (in_valid/in_stall/in_data): one operation word per handshake:
// tick, start, stop or query. in_stall stays high while an operation is worked.
// Start and stop are done when accepted. A query gives one status
// word. A tick walks the timers in index order through one shared update unit:
// a disarmed timer is skipped; an armed timer takes a store read, then an update
// and, unless it expired, a write back. The final word is flushed at the end.
// The registered store read port is why an armed timer needs a read step.
// Result channel (out_valid/out_stall/out_data): expiry words of a tick in
// index order, the final one with last set; one status word per query.
// A full output register with the receiver stalling holds the walk in place;
// nothing is dropped.
// cfg_wr_en/cfg_wr_data load the tick step (ms); write it only while idle.
// Reset (rst_n low, synchronous) disarms all timers, sets the step to 1000 and
// empties the output; the entry store needs no clearing since entries are
// only read while their timer is armed.
`include "one_shot_timer_bank_core_assert.svh"
module one_shot_timer_bank_core #(
  parameter int TIMER_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ostb_pkg::ostb_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ostb_pkg::ostb_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import ostb_pkg::*;

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
  localparam logic [7:0] ID_LIMIT = 8'(TIMER_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EXEC,
    ST_FLUSH
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIMER_COUNT-1:0] armed_r, armed_nxt;
  logic [15:0]            step_r, step_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  ostb_out_t              pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ostb_out_t              out_r, out_nxt;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] wr_addr;
  ostb_entry_t      wr_data, rd_data;
  ostb_upd_t        upd_res;

  logic             in_acc, out_free, id_ok;
  logic [IDX_W-1:0] id_idx;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign id_ok     = (in_data.timer_id < ID_LIMIT);
  assign id_idx    = in_data.timer_id[IDX_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ostb_store #(
    .DEPTH (TIMER_COUNT),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  ostb_upd u_upd (
    .elapsed  (rd_data.elapsed),
    .interval (rd_data.interval),
    .step     (step_r),
    .res      (upd_res)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    armed_nxt      = armed_r;
    step_nxt       = step_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{interval: rd_data.interval, elapsed: upd_res.elapsed};

    // Output word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      step_nxt = cfg_wr_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.mode)
            MODE_TICK: begin
              idx_nxt   = '0;
              state_nxt = ST_WALK;
            end
            MODE_START: begin
              if (id_ok) begin
                armed_nxt[id_idx] = 1'b1;
                wr_en   = 1'b1;
                wr_addr = id_idx;
                wr_data = '{interval: in_data.interval_ms, elapsed: 32'd0};
              end
            end
            MODE_STOP: begin
              if (id_ok) begin
                armed_nxt[id_idx] = 1'b0;
              end
            end
            MODE_QUERY: begin
              pend_nxt.kind        = KIND_STATUS;
              pend_nxt.which_timer = in_data.timer_id;
              pend_nxt.armed       = id_ok && armed_r[id_idx];
              pend_nxt.last        = 1'b1;
              pend_valid_nxt       = 1'b1;
              state_nxt            = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      // Skip disarmed timers, read armed ones
      ST_WALK: begin
        if (armed_r[idx_r]) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // Update one armed timer; an expiry pushes the previous pending word out
      ST_EXEC: begin
        if (!upd_res.expired || !pend_valid_r || out_free) begin
          if (upd_res.expired) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_nxt.kind        = KIND_EXPIRY;
            pend_nxt.which_timer = 8'(idx_r);
            pend_nxt.armed       = 1'b0;
            pend_nxt.last        = 1'b0;
            pend_valid_nxt       = 1'b1;
            armed_nxt[idx_r]     = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_WALK;
          end
        end
      end
      // Final word of the item carries last
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_nxt.last   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      armed_r      <= '0;
      step_r       <= STEP_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      armed_r      <= armed_nxt;
      step_r       <= step_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Checks
  `OSTB_ASSERT_IMP(a_exec_armed, clk, rst_n, state_r == ST_EXEC, armed_r[idx_r])
  `OSTB_ASSERT_IMP(a_status_last, clk, rst_n, out_valid_r && (out_r.kind == KIND_STATUS), out_r.last)
  `OSTB_ASSERT_IMP(a_expiry_disarmed, clk, rst_n, out_valid_r && (out_r.kind == KIND_EXPIRY), !out_r.armed)
  `OSTB_ASSERT_NXT(a_start_arms, clk, rst_n, in_acc && (in_data.mode == MODE_START) && id_ok, armed_r[$past(id_idx)])

endmodule

// ===== rtl/core/ostb_store.sv =====
// Timer entry store: one write port, one registered read port.
module ostb_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ostb_pkg::ostb_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ostb_pkg::ostb_entry_t rd_data
);
  import ostb_pkg::*;

  ostb_entry_t mem [DEPTH];
  ostb_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/ostb_upd.sv =====
// Shared update unit: saturating add of the tick step and expiry compare.
module ostb_upd (
  input  logic [31:0]        elapsed,
  input  logic [31:0]        interval,
  input  logic [15:0]        step,
  output ostb_pkg::ostb_upd_t res
);
  import ostb_pkg::*;

  logic [32:0] sum;
  logic [31:0] sat;

  // Saturating add
  assign sum = {1'b0, elapsed} + {17'd0, step};
  assign sat = sum[32] ? ELAPSED_MAX : sum[31:0];

  // Expiry compare
  assign res.elapsed = sat;
  assign res.expired = (sat >= interval);

endmodule
